### sv/hpq_pkg.sv
// Shared types and constants for the max-heap priority queue.
package hpq_pkg;

	localparam int KEY_W  = 32;
	localparam int FILL_W = 8;

	typedef logic signed [KEY_W-1:0] key_t;
	typedef logic [FILL_W-1:0]       fill_t;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// Operation codes on the request channel
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

endpackage

### sv/hpq_if.sv
// Valid/ready channel interfaces for requests and responses of the heap queue.
interface hpq_req_if;
	logic               valid;
	logic               ready;
	logic               action;
	hpq_pkg::key_t      key_in;

	modport source (output valid, output action, output key_in, input ready);
	modport sink (input valid, input action, input key_in, output ready);
endinterface

interface hpq_rsp_if;
	logic               valid;
	logic               ready;
	hpq_pkg::key_t      key_out;
	hpq_pkg::status_t   status;
	hpq_pkg::fill_t     fill_count;

	modport source (output valid, output key_out, output status, output fill_count,
		input ready);
	modport sink (input valid, input key_out, input status, input fill_count,
		output ready);
endinterface

### sv/hpq_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module hpq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, registered
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### sv/max_heap_priority_queue.sv
// Binary max-heap priority queue: top level with the sift sequencer and heap memory.
//
// Usage:
//   req channel: action (0 insert key_in, 1 remove maximum) and key_in. A transfer
//   happens when req.valid and req.ready are both high; ready is high only while
//   the sequencer is idle, so one operation is in flight at a time.
//   rsp channel: one transfer per request with key_out (removed key, else 0),
//   status (ok, insert dropped on full, remove on empty) and fill_count (keys held
//   after the operation, low 8 bits).
// Sequencing:
//   Insert reads the parent, then the key rises one level per heap read and write;
//   remove reads the root, then the last entry, then sinks the moved entry one level
//   per left read followed by right read with compare and write. Full and empty go
//   straight to the response. The single heap read port sets this pace.
// Reset: the key count clears to zero; heap memory contents are not cleared,
//   entries are only read below the count.
// Stall: a finished response sits in the output register; the next request can be
//   taken while it waits, but its response is held until rsp.ready frees the register.
module max_heap_priority_queue #(
	parameter int CAPACITY = 128
) (
	input  logic      clk,
	input  logic      arst_n,
	hpq_req_if.sink   req,
	hpq_rsp_if.source rsp
);

	import hpq_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
	localparam logic [CW-1:0] POS_ROOT = CW'(1);

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_UP    = 8'b0000_0010,
		S_WR    = 8'b0000_0100,
		S_ROOT  = 8'b0000_1000,
		S_LAST  = 8'b0001_0000,
		S_DNRR  = 8'b0010_0000,
		S_DNCMP = 8'b0100_0000,
		S_DONE  = 8'b1000_0000
	} state_t;

	// 1-based heap position to memory address
	function automatic logic [AW-1:0] pos2addr(input logic [CW:0] p);
		logic [CW:0] m;
		m = p - 1'b1;
		return m[AW-1:0];
	endfunction

	state_t          state_q, state_d;
	logic [CW-1:0]   count_q, count_d;
	logic            rsp_valid_q;

	logic [CW-1:0]   pos_q;
	key_t            key_q;
	key_t            res_q;
	status_t         stat_q;
	key_t            left_q;
	logic            has_right_q;

	key_t            rsp_key_q;
	status_t         rsp_stat_q;
	fill_t           rsp_fill_q;

	logic            we, re;
	logic [AW-1:0]   waddr, raddr;
	logic [KEY_W-1:0] wdata, rdata;
	key_t            rd_key;

	logic            req_xfer, rsp_load;
	logic [CW-1:0]   cnt_inc, parent, gparent, cpos;
	logic [CW:0]     cnt_ext, lchild, rchild, c2;
	logic            up_swap, dn_swap, pick_right;
	key_t            cval;

	hpq_ram #(
		.WIDTH (KEY_W),
		.DEPTH (CAPACITY)
	) u_heap_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign rd_key   = key_t'(rdata);
	assign req_xfer = req.valid && req.ready;
	assign rsp_load = (state_q == S_DONE) && (!rsp_valid_q || rsp.ready);

	// Position arithmetic
	assign cnt_inc = count_q + 1'b1;
	assign cnt_ext = {1'b0, count_q};
	assign parent  = pos_q >> 1;
	assign gparent = pos_q >> 2;
	assign lchild  = {pos_q, 1'b0};
	assign rchild  = {pos_q, 1'b1};

	// Sift-up: key rises while strictly above its parent
	assign up_swap = key_q > rd_key;

	// Sift-down: right child only when strictly larger; sink while below the child
	assign pick_right = has_right_q && (left_q < rd_key);
	assign cval       = pick_right ? rd_key : left_q;
	assign cpos       = pick_right ? rchild[CW-1:0] : lchild[CW-1:0];
	assign c2         = {cpos, 1'b0};
	assign dn_swap    = key_q < cval;

	// Sequencer next state and memory port control
	always_comb begin
		state_d = state_q;
		count_d = count_q;
		re      = 1'b0;
		raddr   = '0;
		we      = 1'b0;
		waddr   = pos2addr({1'b0, pos_q});
		wdata   = key_q;
		case (state_q)
			S_IDLE: begin
				if (req_xfer) begin
					re = 1'b1;
					if (req.action == OP_INSERT) begin
						raddr = pos2addr({1'b0, cnt_inc >> 1});
						if (count_q == CAP_C) begin
							state_d = S_DONE;
						end else begin
							count_d = cnt_inc;
							state_d = (cnt_inc == POS_ROOT) ? S_WR : S_UP;
						end
					end else begin
						raddr = '0;
						if (count_q == '0) begin
							state_d = S_DONE;
						end else begin
							count_d = count_q - 1'b1;
							state_d = S_ROOT;
						end
					end
				end
			end
			S_UP: begin
				we = 1'b1;
				if (up_swap) begin
					wdata = rdata;
					if (parent > POS_ROOT) begin
						re      = 1'b1;
						raddr   = pos2addr({1'b0, gparent});
						state_d = S_UP;
					end else begin
						state_d = S_WR;
					end
				end else begin
					state_d = S_DONE;
				end
			end
			S_WR: begin
				we      = 1'b1;
				state_d = S_DONE;
			end
			S_ROOT: begin
				// last entry sits at the old count position
				re      = 1'b1;
				raddr   = count_q[AW-1:0];
				state_d = S_LAST;
			end
			S_LAST: begin
				if (count_q == POS_ROOT) begin
					we      = 1'b1;
					waddr   = '0;
					wdata   = rdata;
					state_d = S_DONE;
				end else if (count_q == '0) begin
					state_d = S_DONE;
				end else begin
					re      = 1'b1;
					raddr   = AW'(1);
					state_d = S_DNRR;
				end
			end
			S_DNRR: begin
				re      = (rchild <= cnt_ext);
				raddr   = pos2addr(rchild);
				state_d = S_DNCMP;
			end
			S_DNCMP: begin
				we = 1'b1;
				if (dn_swap) begin
					wdata = cval;
					if (c2 <= cnt_ext) begin
						re      = 1'b1;
						raddr   = pos2addr(c2);
						state_d = S_DNRR;
					end else begin
						state_d = S_WR;
					end
				end else begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (rsp_load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Working registers and response payload
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (req_xfer) begin
					key_q  <= req.key_in;
					res_q  <= '0;
					stat_q <= ST_OK;
					pos_q  <= cnt_inc;
					if (req.action == OP_INSERT) begin
						if (count_q == CAP_C) begin
							stat_q <= ST_FULL;
						end
					end else if (count_q == '0) begin
						stat_q <= ST_EMPTY;
					end
				end
			end
			S_UP: begin
				if (up_swap) begin
					pos_q <= parent;
				end
			end
			S_ROOT: begin
				res_q <= rd_key;
			end
			S_LAST: begin
				key_q <= rd_key;
				pos_q <= POS_ROOT;
			end
			S_DNRR: begin
				left_q      <= rd_key;
				has_right_q <= (rchild <= cnt_ext);
			end
			S_DNCMP: begin
				if (dn_swap) begin
					pos_q <= cpos;
				end
			end
			S_DONE: begin
				if (rsp_load) begin
					rsp_key_q  <= res_q;
					rsp_stat_q <= stat_q;
					rsp_fill_q <= FILL_W'(count_q);
				end
			end
			default: begin
			end
		endcase
	end

	assign req.ready      = (state_q == S_IDLE);
	assign rsp.valid      = rsp_valid_q;
	assign rsp.key_out    = rsp_key_q;
	assign rsp.status     = rsp_stat_q;
	assign rsp.fill_count = rsp_fill_q;

	// Key count never exceeds the capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_C)
		else $error("heap count above capacity");

	// Accepted insert into a non-full heap grows the count by one
	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		(req_xfer && req.action == OP_INSERT && count_q != CAP_C)
		|=> count_q == $past(count_q) + CW'(1))
		else $error("insert did not grow count");

	// Accepted remove from a non-empty heap shrinks the count by one
	a_remove_count: assert property (@(posedge clk) disable iff (!arst_n)
		(req_xfer && req.action == OP_REMOVE && count_q != '0)
		|=> count_q == $past(count_q) - CW'(1))
		else $error("remove did not shrink count");

	// Heap memory is never written while idle or holding a result
	a_no_idle_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE || state_q == S_DONE) |-> !we)
		else $error("heap write outside an operation");

endmodule
